FILE: rtl/core/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg - shared definitions for the clock page replacement block
// Sizes, frame cell command codes, controller states and the one-hot encoder.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_WIDTH = 16;

  localparam int FrameW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW   = $clog2(MAX_FRAMES + 1);
  localparam int CfgW   = 4;

  localparam logic [CfgW-1:0] FramesReset = 4'd8;

  // Byte address of the frame count register
  localparam logic [2:0] AddrFrames = 3'd0;

  typedef logic [PAGE_WIDTH-1:0] page_t;
  typedef logic [FrameW-1:0]     frame_idx_t;
  typedef logic [MAX_FRAMES-1:0] frame_vec_t;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_LOOK,
    CMD_STEP
  } cell_cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SWEEP,
    S_DONE
  } cpr_state_e;

  // Broadcast from the controller to every frame cell
  typedef struct packed {
    cell_cmd_e cmd;
    page_t     page;
    logic      wrap;
  } cell_ctrl_t;

  // Index of the set bit of a one-hot vector
  function automatic frame_idx_t onehot_to_idx(frame_vec_t vec);
    frame_idx_t idx;
    idx = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (vec[i]) begin
        idx = idx | frame_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/cpr_cell.sv
// ----------------------------------------------------------------------------
// cpr_cell - one page frame of the clock
// Holds page, valid and use bits and the hand token; ripples the match chain.
// ----------------------------------------------------------------------------
module cpr_cell import cpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       active_i,
  input  logic       home_i,
  input  logic       found_i,
  input  logic       token_i,
  output logic       found_o,
  output logic       first_o,
  output logic       pass_o,
  output logic       fill_o,
  output logic       token_o
);

  page_t page_q, page_d;
  logic  valid_q, valid_d;
  logic  use_q, use_d;
  logic  token_q, token_d;
  logic  match;

  assign match   = valid_q & active_i & (page_q == ctrl_i.page);
  assign first_o = match & ~found_i;
  assign found_o = found_i | match;
  assign pass_o  = token_q & (ctrl_i.cmd == CMD_STEP);
  assign fill_o  = pass_o & ~use_q;
  assign token_o = token_q;

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    use_d   = use_q;
    token_d = token_q;
    case (ctrl_i.cmd)
      CMD_LOOK: begin
        if (first_o) begin
          use_d = 1'b1;
        end
        if (ctrl_i.wrap) begin
          token_d = home_i;
        end
      end
      CMD_STEP: begin
        // hand leaves this frame either way; take whatever the neighbour hands on
        token_d = token_i;
        if (token_q) begin
          if (use_q) begin
            use_d = 1'b0;
          end else begin
            page_d  = ctrl_i.page;
            valid_d = 1'b1;
            use_d   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      use_q   <= 1'b0;
      token_q <= home_i;
    end else begin
      valid_q <= valid_d;
      use_q   <= use_d;
      token_q <= token_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

FILE: rtl/core/clock_page_replacement_top.sv
// ----------------------------------------------------------------------------
// clock_page_replacement_top - second-chance clock page replacement
// A row of frame cells with a circulating hand token, a small controller,
// an output word register and an APB-style frame count register.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | page_number_i
//  out     | output    | out_valid_o / out_stall_i | hit, frame_index, hand, faults
//  cfg     | input     | psel/penable/pwrite/pready| frames_in_use at address 0
//
//  A hit goes from acceptance to the result word by way of accept, lookup,
//  then load of the output register. A fault adds a sweep step for each frame
//  the hand visits, as the hand token walks the cell row one frame per cycle.
//  One page is in work at a time; in_stall_o is high from acceptance until
//  the result word is loaded. A full output register that is stalled holds
//  the finished word in the controller until it frees.
//  Reset clears valid and use bits, the hand and the fault counter at once;
//  page contents are not cleared, so no sweep follows reset.
//
module clock_page_replacement_top import cpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] page_number_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [2:0]  frame_index_o,
  output logic [2:0]  hand_position_o,
  output logic [31:0] fault_count_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] frames_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr == AddrFrames);
  assign prdata = (paddr == AddrFrames) ? 32'(frames_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesReset;
    end else if (cfg_wr) begin
      frames_q <= pwdata[CfgW-1:0];
    end
  end

  // Clamp the frame count to 1..MAX_FRAMES
  logic [CntW-1:0] n_eff;

  always_comb begin
    if (frames_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      n_eff = CntW'(MAX_FRAMES);
    end else begin
      n_eff = CntW'(frames_q);
    end
  end

  // --------------------------------------------------------------------------
  // Controller state and datapath registers
  // --------------------------------------------------------------------------
  cpr_state_e  state_q, state_d;
  page_t       page_q;
  logic        hit_q, hit_d;
  frame_idx_t  slot_q, slot_d;
  logic [31:0] faults_q, faults_d;

  logic        out_valid_q, out_valid_d;
  logic        out_hit_q;
  logic [2:0]  out_frame_q;
  logic [2:0]  out_hand_q;
  logic [31:0] out_faults_q;

  logic        in_accept;
  logic        load_out;
  cell_ctrl_t  cell_ctrl;

  // Cell row signals
  frame_vec_t  active_vec, last_vec, home_vec;
  frame_vec_t  first_vec, pass_vec, fill_vec, token_vec, token_in_vec;
  logic [MAX_FRAMES:0] found_chain;
  frame_idx_t  hand_idx;
  logic        any_hit, any_fill;

  assign hand_idx  = onehot_to_idx(token_vec);
  assign any_hit   = found_chain[MAX_FRAMES];
  assign any_fill  = |fill_vec;
  assign in_accept = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Frame cell row: match chain ripples up, hand token passes to the neighbour
  // and wraps from the last active frame back to frame 0.
  // --------------------------------------------------------------------------
  assign found_chain[0]  = 1'b0;
  assign token_in_vec[0] = |(pass_vec & last_vec);

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    assign active_vec[g] = (32'(g) < 32'(n_eff));
    assign last_vec[g]   = (32'(g) == (32'(n_eff) - 32'd1));
    assign home_vec[g]   = (g == 0);

    if (g > 0) begin : g_link
      assign token_in_vec[g] = pass_vec[g-1] & ~last_vec[g-1];
    end

    cpr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .active_i (active_vec[g]),
      .home_i   (home_vec[g]),
      .found_i  (found_chain[g]),
      .token_i  (token_in_vec[g]),
      .found_o  (found_chain[g+1]),
      .first_o  (first_vec[g]),
      .pass_o   (pass_vec[g]),
      .fill_o   (fill_vec[g]),
      .token_o  (token_vec[g])
    );
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = any_hit ? S_DONE : S_SWEEP;
      end
      S_SWEEP: begin
        if (any_fill) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o     = (state_q != S_IDLE);
    load_out       = 1'b0;
    cell_ctrl.cmd  = CMD_IDLE;
    cell_ctrl.page = page_q;
    // pull the hand home when the frame count has shrunk under it
    cell_ctrl.wrap = (32'(hand_idx) >= 32'(n_eff));
    hit_d          = hit_q;
    slot_d         = slot_q;
    faults_d       = faults_q;
    case (state_q)
      S_LOOK: begin
        cell_ctrl.cmd = CMD_LOOK;
        hit_d         = any_hit;
        slot_d        = onehot_to_idx(first_vec);
      end
      S_SWEEP: begin
        cell_ctrl.cmd = CMD_STEP;
        if (any_fill) begin
          slot_d = onehot_to_idx(fill_vec);
          if (faults_q != '1) begin
            faults_d = faults_q + 32'd1;
          end
        end
      end
      S_DONE: begin
        load_out = ~out_valid_q | ~out_stall_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      faults_q <= '0;
    end else begin
      state_q  <= state_d;
      faults_q <= faults_d;
    end
  end

  // Payload of the item in work
  logic [31:0] page_ext;
  assign page_ext = 32'(page_number_i);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      page_q <= page_ext[PAGE_WIDTH-1:0];
    end
    hit_q  <= hit_d;
    slot_q <= slot_d;
  end

  // --------------------------------------------------------------------------
  // Output word register
  // --------------------------------------------------------------------------
  logic [31:0] slot_ext, hand_ext;
  assign slot_ext = 32'(slot_q);
  assign hand_ext = 32'(hand_idx);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_hit_q    <= hit_q;
      out_frame_q  <= slot_ext[2:0];
      out_hand_q   <= hand_ext[2:0];
      out_faults_q <= faults_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign frame_index_o   = out_frame_q;
  assign hand_position_o = out_hand_q;
  assign fault_count_o   = out_faults_q;

`ifndef NO_ASSERTIONS
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(token_vec))
    else $error("hand token lost or duplicated");

  a_single_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fill_vec))
    else $error("more than one frame filled in a sweep step");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_LOOK))
    else $error("accepted page did not enter lookup");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !hit_q) |=> (fault_count_o != 32'd0))
    else $error("fault word reported with zero fault count");

  a_fill_in_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_fill |-> ((fill_vec & ~active_vec) == '0))
    else $error("sweep filled a frame outside the frame count");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for clock_page_replacement_top
// Drives page references through the valid/stall input channel, changes the
// frame count over the APB-style port between phases, and checks every result
// word against a typed row or an internal second-chance replacement predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import cpr_pkg::*;

  // Give up after this many cycles in which no word moves on any channel
  localparam int IdleLimit = 1000;
  // Cycles to let pass once the last result word has arrived
  localparam int DrainCycles = 16;
  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 65;
  localparam int PoolSize = 10;

  // One result word as the block reports it
  typedef struct packed {
    logic        hit;
    logic [2:0]  frame;
    logic [2:0]  hand;
    logic [31:0] faults;
  } page_result_t;

  typedef enum logic {
    ROW_PAGE,
    ROW_FRAMES
  } row_kind_e;

  // A directed row: either a page reference or a new frame count. Where
  // typed is set, the expected word is the one written in the row.
  typedef struct packed {
    row_kind_e    kind;
    logic [15:0]  value;
    logic         typed;
    page_result_t exp;
  } ref_row_t;

  localparam int NumDirected = 24;
  localparam ref_row_t DirectedRefs [NumDirected] = '{
    // page zero must fault on an empty table, then hit
    '{ROW_PAGE,   16'h0000, 1'b1, '{1'b0, 3'd0, 3'd1, 32'd1}},
    '{ROW_PAGE,   16'h0000, 1'b1, '{1'b1, 3'd0, 3'd1, 32'd1}},
    '{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b0, 3'd1, 3'd2, 32'd2}},
    '{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b1, 3'd1, 3'd2, 32'd2}},
    // fill the remaining frames; the hand wraps after the last one
    '{ROW_PAGE,   16'h8000, 1'b0, '0},
    '{ROW_PAGE,   16'h5555, 1'b0, '0},
    '{ROW_PAGE,   16'hAAAA, 1'b0, '0},
    '{ROW_PAGE,   16'h0001, 1'b0, '0},
    '{ROW_PAGE,   16'h7FFF, 1'b0, '0},
    '{ROW_PAGE,   16'h1234, 1'b0, '0},
    // every use bit set: a full clearing pass before the victim is found
    '{ROW_PAGE,   16'h4321, 1'b0, '0},
    '{ROW_PAGE,   16'h0000, 1'b0, '0},
    // shrink the count; frames beyond it keep their pages but never match
    '{ROW_FRAMES, 16'd3,    1'b0, '0},
    '{ROW_PAGE,   16'h5555, 1'b0, '0},
    '{ROW_PAGE,   16'hAAAA, 1'b0, '0},
    // a count of zero behaves as one frame
    '{ROW_FRAMES, 16'd0,    1'b0, '0},
    '{ROW_PAGE,   16'h00FF, 1'b0, '0},
    '{ROW_PAGE,   16'h00FF, 1'b0, '0},
    '{ROW_PAGE,   16'hFF00, 1'b0, '0},
    // a count above the maximum behaves as the maximum
    '{ROW_FRAMES, 16'd15,   1'b0, '0},
    '{ROW_PAGE,   16'h5555, 1'b0, '0},
    '{ROW_FRAMES, 16'd1,    1'b0, '0},
    // with one frame this lands in frame 0 while an old copy sits higher up
    '{ROW_PAGE,   16'h1234, 1'b0, '0},
    '{ROW_FRAMES, 16'd8,    1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] page_number_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        hit_o;
  logic [2:0]  frame_index_o;
  logic [2:0]  hand_position_o;
  logic [31:0] fault_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  clock_page_replacement_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .hand_position_o(hand_position_o),
    .fault_count_o  (fault_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the frame table and the register
  // --------------------------------------------------------------------------
  page_t            table_pages [MAX_FRAMES];
  frame_vec_t       table_valid = '0;
  frame_vec_t       table_use = '0;
  frame_idx_t       clock_hand = '0;
  logic [31:0]      fault_total = '0;
  logic [CfgW-1:0]  frames_setting = FramesReset;

  page_result_t     pending_results [$];
  int unsigned      fail_count = 0;
  int unsigned      idle_cycles = 0;
  logic             quiet = 1'b0;

  // Apply one page reference to the predictor state and return the word
  // the block should report for it.
  function automatic page_result_t replace_page(page_t pg);
    int unsigned  n;
    int unsigned  slot;
    int unsigned  h;
    int unsigned  i;
    logic         found;
    logic         placed;
    page_result_t r;
    n = 32'(frames_setting);
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    slot = 0;
    found = 1'b0;
    placed = 1'b0;
    // a hand left beyond a shrunken count starts again from frame 0
    if (int'(clock_hand) >= n) clock_hand = '0;
    for (i = 0; i < n; i++) begin
      if (!found && table_valid[i] && table_pages[i] == pg) begin
        table_use[i] = 1'b1;
        slot = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      // second chance: clear set use bits, take the first clear one
      for (i = 0; i < 2 * n + 1; i++) begin
        if (!placed) begin
          h = 32'(clock_hand);
          clock_hand = (h + 1 >= n) ? frame_idx_t'(0) : frame_idx_t'(h + 1);
          if (!table_use[h]) begin
            table_use[h] = 1'b1;
            table_pages[h] = pg;
            table_valid[h] = 1'b1;
            slot = h;
            placed = 1'b1;
          end else begin
            table_use[h] = 1'b0;
          end
        end
      end
      if (fault_total != '1) fault_total = fault_total + 1;
    end
    r.hit = found;
    r.frame = 3'(slot);
    r.hand = 3'(clock_hand);
    r.faults = fault_total;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel: present one page word, hold it until it is taken, then
  // log what it should produce. Valid is left high so that a following word
  // can go out back to back.
  // --------------------------------------------------------------------------
  task automatic send_page(input page_t pg, input logic typed, input page_result_t exp);
    page_result_t predicted;
    // drop valid for a short gap now and then
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    page_number_i <= pg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = replace_page(pg);
    pending_results.push_back(typed ? exp : predicted);
  endtask

  // Write the frame count once the block has drained. Upper data bits are
  // random: the register keeps only its low four.
  task automatic write_frames(input logic [CfgW-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrFrames;
    pwdata <= {28'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    frames_setting = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall, except in the quiet phase
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 99) < 10);
  end

  // Compare each result word taken with the oldest expectation
  always @(posedge clk_i) begin
    page_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected: hit %0d frame %0d hand %0d faults %0d",
                 $time, hit_o, frame_index_o, hand_position_o, fault_count_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit_o);
          fail_count++;
        end
        if (frame_index_o !== want.frame) begin
          $display("%0t: frame_index expected %0d actual %0d", $time, want.frame,
                   frame_index_o);
          fail_count++;
        end
        if (hand_position_o !== want.hand) begin
          $display("%0t: hand_position expected %0d actual %0d", $time, want.hand,
                   hand_position_o);
          fail_count++;
        end
        if (fault_count_o !== want.faults) begin
          $display("%0t: fault_count expected %0d actual %0d", $time, want.faults,
                   fault_count_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("clock_page_replacement_top: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    page_t                 pool [PoolSize];
    page_t                 pg;
    logic [CfgW-1:0]       phase_frames [NumPhases];
    int                    r;
    int                    ph;
    int                    k;
    phase_frames = '{4'd5, 4'd1, 4'd8, 4'd2, 4'd15, 4'd0, 4'd7, 4'd3, 4'd4, 4'd6};

    // hold reset, then release it at an edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part: start from the reset frame count
    for (r = 0; r < NumDirected; r++) begin
      if (DirectedRefs[r].kind == ROW_FRAMES) begin
        write_frames(DirectedRefs[r].value[CfgW-1:0]);
      end else begin
        send_page(DirectedRefs[r].value, DirectedRefs[r].typed, DirectedRefs[r].exp);
      end
    end

    // Random part: one frame count per phase. Most references come from a
    // small working set so that hits, second chances and evictions all
    // occur; the rest are arbitrary pages to toggle every bit.
    for (ph = 0; ph < NumPhases; ph++) begin
      write_frames(phase_frames[ph]);
      // the third phase runs with no gaps and no stalls on either side
      quiet = (ph == 2);
      for (k = 0; k < PoolSize; k++) begin
        pool[k] = ($urandom_range(0, 1) != 0) ? page_t'($urandom_range(0, 15)) :
                                                 page_t'($urandom_range(0, 65535));
      end
      for (k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(0, 99) < 75) pg = pool[$urandom_range(0, PoolSize - 1)];
        else pg = page_t'($urandom_range(0, 65535));
        send_page(pg, 1'b0, '0);
      end
      quiet = 1'b0;
    end

    // Drain: drop valid, wait for the last word, then wait out DrainCycles
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("clock_page_replacement_top: match");
    end else begin
      $display("clock_page_replacement_top: mismatch");
    end
    $finish;
  end

endmodule
